// File: rtl/core/double_ended_queue_defines.svh
// Assertion macros shared by the deque RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

	// Default ring depth and the width of one stored value.
	localparam int DEQ_DEPTH = 64;
	localparam int DATA_W    = 32;

	// Operation codes carried in the opcode field.
	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PEEK       = 3'd4,
		OP_DUMP       = 3'd5
	} deq_op_t;

	// Status codes returned with every result.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} deq_status_t;

	// Control states of the deque sequencer.
	typedef enum logic {
		S_IDLE,
		S_DUMP
	} deq_state_t;

	// Request payload.
	typedef struct packed {
		logic [2:0]               opcode;
		logic signed [DATA_W-1:0] value;
	} deq_req_t;

	// Response payload.
	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] data;
		logic                     last;
	} deq_rsp_t;

endpackage

// File: rtl/core/double_ended_queue.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// request   in         req_valid/req_ready   req (deq_req_t: opcode, value)
// response  out        rsp_valid/rsp_ready   rsp (deq_rsp_t: status, data, last)
//
// Pushes and every empty or full reply are loaded straight into the response register;
// pops and peek first pass through the registered read of the ring memory.
// A dump streams one response per cycle, one per stored entry, while responses do not stall.
// Requests are taken one at a time; a new one is accepted once the previous one
// has left the read stage and the response register is free or being drained.
// Reset clears the pointers, the count and all valid flags; memory is not cleared.
// A stalled response holds the read stage and the dump sequencer in place.

`include "double_ended_queue_defines.svh"

module double_ended_queue
	import deq_pkg::*;
#(
	parameter int DEPTH = DEQ_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  deq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output deq_rsp_t rsp
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW:0]   DEPTH_W = (PW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);

	// Ring position of an offset from a base pointer.
	function automatic logic [PW-1:0] ring_pos(input logic [PW-1:0] base,
			input logic [PW-1:0] off);
		logic [PW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		return sum[PW-1:0];
	endfunction

	deq_state_t state_q, state_d;
	logic [PW-1:0] front_q, front_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] count_dec;
	logic [PW-1:0] dump_idx_q;
	logic          v_s1, last_s1;
	logic          rsp_valid_q;
	deq_rsp_t      rsp_q;

	logic accept, rsp_free, full, empty;
	logic dump_issue, dump_last;
	logic wr_en, rd_en, load_direct;
	logic [PW-1:0] wr_addr, rd_addr;
	logic signed [DATA_W-1:0] rd_data;
	deq_rsp_t direct_rsp;

	assign accept    = req_valid && req_ready;
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign full      = (count_q == DEPTH_C);
	assign empty     = (count_q == '0);
	assign count_dec = count_q - CW'(1);
	assign dump_last = (dump_idx_q == count_dec[PW-1:0]);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && req.opcode == OP_DUMP && !empty) begin
					state_d = S_DUMP;
				end
			end
			S_DUMP: begin
				if (dump_issue && dump_last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		req_ready  = 1'b0;
		dump_issue = 1'b0;
		case (state_q)
			S_IDLE: req_ready = !v_s1 && rsp_free;
			S_DUMP: dump_issue = !v_s1 || rsp_free;
			default: ;
		endcase
	end

	// Operation decode: pointer updates, memory accesses and direct replies.
	always_comb begin
		front_d     = front_q;
		count_d     = count_q;
		wr_en       = 1'b0;
		wr_addr     = front_q;
		rd_en       = 1'b0;
		rd_addr     = front_q;
		load_direct = 1'b0;
		direct_rsp  = '{status: ST_OK, data: '0, last: 1'b1};
		if (accept) begin
			case (req.opcode)
				OP_PUSH_FRONT, OP_PUSH_BACK: begin
					load_direct = 1'b1;
					if (full) begin
						direct_rsp.status = ST_FULL;
					end else begin
						wr_en   = 1'b1;
						count_d = count_q + CW'(1);
						if (req.opcode == OP_PUSH_FRONT) begin
							front_d = (front_q == '0) ? LAST_P : front_q - PW'(1);
							wr_addr = front_d;
						end else begin
							wr_addr = ring_pos(front_q, count_q[PW-1:0]);
						end
					end
				end
				OP_POP_FRONT, OP_POP_BACK, OP_PEEK: begin
					if (empty) begin
						load_direct       = 1'b1;
						direct_rsp.status = ST_EMPTY;
					end else begin
						rd_en = 1'b1;
						if (req.opcode == OP_POP_BACK) begin
							rd_addr = ring_pos(front_q, count_dec[PW-1:0]);
							count_d = count_dec;
						end else if (req.opcode == OP_POP_FRONT) begin
							front_d = (front_q == LAST_P) ? '0 : front_q + PW'(1);
							count_d = count_dec;
						end
					end
				end
				OP_DUMP: begin
					if (empty) begin
						load_direct       = 1'b1;
						direct_rsp.status = ST_EMPTY;
					end
				end
				default: ;
			endcase
		end else if (dump_issue) begin
			rd_en   = 1'b1;
			rd_addr = ring_pos(front_q, dump_idx_q);
		end
	end

	deq_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (PW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (req.value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Control registers: state, pointers, read stage and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			dump_idx_q  <= '0;
			v_s1        <= 1'b0;
			last_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			if (accept) begin
				dump_idx_q <= '0;
			end else if (dump_issue) begin
				dump_idx_q <= dump_idx_q + PW'(1);
			end
			if (rd_en) begin
				v_s1    <= 1'b1;
				last_s1 <= (state_q == S_DUMP) ? dump_last : 1'b1;
			end else if (v_s1 && rsp_free) begin
				v_s1 <= 1'b0;
			end
			if (load_direct || (v_s1 && rsp_free)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload register.
	always_ff @(posedge clk) begin
		if (load_direct) begin
			rsp_q <= direct_rsp;
		end else if (v_s1 && rsp_free) begin
			rsp_q <= '{status: ST_OK, data: rd_data, last: last_s1};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The entry count never goes beyond the ring depth.
	`DEQ_ASSERT_SAME(a_count_bound, 1'b1, count_q <= DEPTH_C, "entry count exceeds depth")
	// A dump leaves the queue contents and pointers alone.
	`DEQ_ASSERT_NEXT(a_dump_stable, state_q == S_DUMP,
		$stable(count_q) && $stable(front_q), "queue changed during dump")
	// A push on a full queue is answered directly from the response register with a full status.
	`DEQ_ASSERT_NEXT(a_push_full, accept && full &&
		(req.opcode == OP_PUSH_FRONT || req.opcode == OP_PUSH_BACK),
		rsp_valid_q && rsp_q.status == ST_FULL && rsp_q.last, "full push not rejected")

endmodule

// File: rtl/core/deq_store.sv
`timescale 1ns / 1ps

module deq_store
	import deq_pkg::*;
#(
	parameter int DEPTH  = DEQ_DEPTH,
	parameter int ADDR_W = $clog2(DEQ_DEPTH)
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [ADDR_W-1:0]        wr_addr,
	input  logic signed [DATA_W-1:0] wr_data,
	input  logic                     rd_en,
	input  logic [ADDR_W-1:0]        rd_addr,
	output logic signed [DATA_W-1:0] rd_data
);

	// Ring storage; contents are undefined until a push writes them.
	logic signed [DATA_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
